[rtl/core/serial_set_time_of_day_clock_macros.svh]
// Assertion helpers shared by the clock's RTL modules.
`ifndef SERIAL_SET_TIME_OF_DAY_CLOCK_MACROS_SVH
`define SERIAL_SET_TIME_OF_DAY_CLOCK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sstc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sstc assertion failed");

`endif

[rtl/core/sstc_pkg.sv]
`default_nettype none
package sstc_pkg;

  // One input request and one report character.
  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_t;

  // Commands passed from the front part to the back part.
  typedef enum logic {
    CMD_TICK,
    CMD_WRITE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] pos;
    logic [7:0] value;
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ADV,
    B_STORE,
    B_EMIT
  } back_state_e;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharOpen    = 8'h5B;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] AsciiZero   = 8'd48;

  localparam logic [2:0] LastPos = 3'd7;

  // Pair counts are at most 255 * 10 + 255 + 1, so twelve bits suffice.
  localparam int unsigned CntW = 12;
  localparam logic [CntW-1:0] MinSecWrap = 12'd60;
  localparam logic [CntW-1:0] HourWrap   = 12'd24;

  // Reciprocal of ten, exact for every twelve-bit count.
  localparam logic [CntW-1:0] Recip10     = 12'd3277;
  localparam int unsigned     Recip10Shift = 15;

  localparam logic [3:0] EmitFirst = 4'd0;
  localparam logic [3:0] EmitLast  = 4'd9;
  localparam logic [1:0] PairLast  = 2'd2;

  localparam logic [7:0] ResetChars [8] = '{
    8'd1, 8'd2, 8'd10, 8'd3, 8'd4, 8'd10, 8'd5, 8'd6
  };

endpackage
`default_nettype wire

[rtl/core/sstc_front.sv]
`default_nettype none
`include "serial_set_time_of_day_clock_macros.svh"
module sstc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sstc_pkg::in_t     in_i,
  input  wire sstc_pkg::q_status_t q_status_i,
  output logic                   push_o,
  output sstc_pkg::cmd_t         cmd_o
);
  import sstc_pkg::*;

  logic       setting_q, setting_d;
  logic [2:0] set_pos_q, set_pos_d;
  logic       accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  // Classify each request and track the set sequence.
  always_comb begin
    setting_d   = setting_q;
    set_pos_d   = set_pos_q;
    push_o      = 1'b0;
    cmd_o.kind  = CMD_TICK;
    cmd_o.pos   = set_pos_q;
    cmd_o.value = in_i.rx_byte - AsciiZero;
    if (accept) begin
      if (!in_i.action) begin
        push_o = !setting_q;
      end else if (in_i.rx_byte == CharPercent) begin
        setting_d = 1'b1;
        set_pos_d = '0;
      end else if (setting_q) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_WRITE;
        if (set_pos_q == LastPos) begin
          setting_d = 1'b0;
          set_pos_d = '0;
        end else begin
          set_pos_d = set_pos_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setting_q <= 1'b0;
      set_pos_q <= '0;
    end else begin
      setting_q <= setting_d;
      set_pos_q <= set_pos_d;
    end
  end

  `SSTC_ASSERT_SAME(a_pos_only_in_set, clk_i, rst_ni, set_pos_q != '0, setting_q)

endmodule
`default_nettype wire

[rtl/core/sstc_queue.sv]
`default_nettype none
`include "serial_set_time_of_day_clock_macros.svh"
module sstc_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sstc_pkg::cmd_t    cmd_i,
  input  wire logic              pop_i,
  output sstc_pkg::cmd_t         head_o,
  output sstc_pkg::q_status_t    status_o
);
  import sstc_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == QCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  `SSTC_ASSERT_SAME(a_no_push_full, clk_i, rst_ni, push_i, !status_o.full)
  `SSTC_ASSERT_SAME(a_no_pop_empty, clk_i, rst_ni, pop_i, !status_o.empty)

endmodule
`default_nettype wire

[rtl/core/sstc_back.sv]
`default_nettype none
`include "serial_set_time_of_day_clock_macros.svh"
module sstc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sstc_pkg::cmd_t      head_i,
  input  wire sstc_pkg::q_status_t q_status_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sstc_pkg::out_t           out_o
);
  import sstc_pkg::*;

  back_state_e         state_q, state_d;
  logic [7:0]          chars_q [8];
  logic [7:0]          chars_d [8];
  logic [CntW-1:0]     cnt_q [3];
  logic [CntW-1:0]     cnt_d [3];
  logic [1:0]          pair_q, pair_d;
  logic [3:0]          emit_q, emit_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic                load;

  logic [CntW-1:0]     hh, mm, ss;
  logic [CntW-1:0]     div_in;
  logic [2*CntW-1:0]   prod;
  logic [8:0]          quot;
  logic [3:0]          rem;
  logic [2:0]          hi_pos;
  logic [2:0]          char_sel;

  // Pair value: high digit times ten plus low digit.
  function automatic logic [CntW-1:0] pair_value(logic [7:0] hi, logic [7:0] lo);
    logic [CntW-1:0] h;
    h = CntW'(hi);
    return (h << 3) + (h << 1) + CntW'(lo);
  endfunction

  // Advance the seconds with carries into minutes and hours.
  always_comb begin
    hh = pair_value(chars_q[0], chars_q[1]);
    mm = pair_value(chars_q[3], chars_q[4]);
    ss = pair_value(chars_q[6], chars_q[7]) + CntW'(1);
    if (ss == MinSecWrap) begin
      ss = '0;
      mm = mm + CntW'(1);
      if (mm == MinSecWrap) begin
        mm = '0;
        hh = hh + CntW'(1);
        if (hh == HourWrap) begin
          hh = '0;
        end
      end
    end
  end

  // Split one count into tens and units by a reciprocal multiply.
  assign div_in   = cnt_q[pair_q];
  assign prod     = (2*CntW)'(div_in) * (2*CntW)'(Recip10);
  assign quot     = prod[Recip10Shift +: 9];
  assign rem      = 4'(div_in - ((CntW'(quot) << 3) + (CntW'(quot) << 1)));
  assign hi_pos   = {pair_q, 1'b0} + {1'b0, pair_q};
  assign char_sel = 3'(emit_q - 4'd1);

  // Sequencer for commands and report emission.
  always_comb begin
    state_d     = state_q;
    chars_d     = chars_q;
    cnt_d       = cnt_q;
    pair_d      = pair_q;
    emit_d      = emit_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    load        = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          if (head_i.kind == CMD_WRITE) begin
            chars_d[head_i.pos] = head_i.value;
          end else begin
            state_d = B_ADV;
          end
        end
      end
      B_ADV: begin
        cnt_d[0] = hh;
        cnt_d[1] = mm;
        cnt_d[2] = ss;
        pair_d   = '0;
        state_d  = B_STORE;
      end
      B_STORE: begin
        chars_d[hi_pos]        = quot[7:0];
        chars_d[hi_pos + 3'd1] = {4'd0, rem};
        if (pair_q == PairLast) begin
          emit_d  = EmitFirst;
          state_d = B_EMIT;
        end else begin
          pair_d = pair_q + 2'd1;
        end
      end
      B_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          out_d.last  = 1'b0;
          if (emit_q == EmitFirst) begin
            out_d.tx_byte = CharOpen;
          end else if (emit_q == EmitLast) begin
            out_d.tx_byte = CharNewline;
            out_d.last    = 1'b1;
          end else begin
            out_d.tx_byte = chars_q[char_sel] + AsciiZero;
          end
          if (emit_q == EmitLast) begin
            state_d = B_IDLE;
          end else begin
            emit_d = emit_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      chars_q     <= ResetChars;
      pair_q      <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chars_q     <= chars_d;
      pair_q      <= pair_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Count and output payload registers.
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SSTC_ASSERT_NEXT(a_last_ends_report, clk_i, rst_ni,
                    load && (emit_q == EmitLast), state_q == B_IDLE)

endmodule
`default_nettype wire

[rtl/core/serial_set_time_of_day_clock.sv]
// A request is taken every cycle while the four-entry command queue has room.
// A set byte is written by the back part as it is popped; a tick takes the back part
// through one pop, one advance, three digit splits and ten report characters.
// The first report character of a tick is registered after the queue, the pop, the advance and the digit splits.
// Reset is asynchronous, active low: time 12:34:56, set mode off, queue empty.
`default_nettype none
module serial_set_time_of_day_clock (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire sstc_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sstc_pkg::out_t      out_o
);
  import sstc_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;

  // Front part: request classification and set-mode tracking.
  sstc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Command queue between the two parts.
  sstc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .head_o   (head_cmd),
    .status_o (q_status)
  );

  // Back part: time keeping and report output.
  sstc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

[dv/serial_set_time_of_day_clock_check.sv]
`default_nettype none
module serial_set_time_of_day_clock_check (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_stall_i,
  input  wire sstc_pkg::in_t  in_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_stall_i,
  input  wire sstc_pkg::out_t out_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DigitBase  = 10;
  localparam int unsigned SecMinWrap = 60;
  localparam int unsigned HoursWrap  = 24;
  localparam int unsigned HoursPos   = 0;
  localparam int unsigned MinutesPos = 3;
  localparam int unsigned SecondsPos = 6;

  // Predicted clock state: one stored byte per character of HH:MM:SS.
  logic [7:0]     clock_chars [8];
  logic           set_mode;
  logic [2:0]     set_pos;
  sstc_pkg::out_t report_q [$];
  sstc_pkg::out_t next_char;
  int unsigned    mismatches = 0;

  // A pair of stored bytes is read as high * 10 + low.
  function automatic int unsigned pair_count(input int unsigned hi);
    return 32'(clock_chars[hi]) * DigitBase + 32'(clock_chars[hi + 1]);
  endfunction

  function automatic void pair_write(input int unsigned hi, input int unsigned count);
    clock_chars[hi + 1] = 8'(count % DigitBase);
    clock_chars[hi]     = 8'(count / DigitBase);
  endfunction

  // Counts wrap only when they land exactly on their limit.
  function automatic void advance_one_second();
    int unsigned hours;
    int unsigned minutes;
    int unsigned seconds;
    hours   = pair_count(HoursPos);
    minutes = pair_count(MinutesPos);
    seconds = pair_count(SecondsPos) + 1;
    if (seconds == SecMinWrap) begin
      seconds = 0;
      minutes++;
      if (minutes == SecMinWrap) begin
        minutes = 0;
        hours++;
        if (hours == HoursWrap) begin
          hours = 0;
        end
      end
    end
    pair_write(HoursPos, hours);
    pair_write(MinutesPos, minutes);
    pair_write(SecondsPos, seconds);
  endfunction

  // A report is the open bracket, the eight characters and a closing newline.
  function automatic void queue_report();
    report_q.push_back(sstc_pkg::out_t'{tx_byte: sstc_pkg::CharOpen, last: 1'b0});
    for (int i = 0; i < 8; i++) begin
      report_q.push_back(sstc_pkg::out_t'{tx_byte: 8'(clock_chars[i] + sstc_pkg::AsciiZero),
                                          last: 1'b0});
    end
    report_q.push_back(sstc_pkg::out_t'{tx_byte: sstc_pkg::CharNewline, last: 1'b1});
  endfunction

  // Ticks are dropped in set mode; bytes matter only in set mode or as a percent sign.
  function automatic void take_request(input sstc_pkg::in_t req);
    if (!req.action) begin
      if (!set_mode) begin
        advance_one_second();
        queue_report();
      end
    end else if (req.rx_byte == sstc_pkg::CharPercent) begin
      set_mode = 1'b1;
      set_pos  = '0;
    end else if (set_mode) begin
      clock_chars[set_pos] = 8'(req.rx_byte - sstc_pkg::AsciiZero);
      if (set_pos == sstc_pkg::LastPos) begin
        set_mode = 1'b0;
        set_pos  = '0;
      end else begin
        set_pos = set_pos + 3'd1;
      end
    end
  endfunction

  task automatic flag_error(input string what);
    $display("%0t ns: report mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Compare each accepted character with the oldest prediction, then predict new requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_chars = '{8'd1, 8'd2, 8'd10, 8'd3, 8'd4, 8'd10, 8'd5, 8'd6};
      set_mode    = 1'b0;
      set_pos     = '0;
      report_q.delete();
      pending_o <= 0;
      errors_o  <= mismatches;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (report_q.size() == 0) begin
          flag_error($sformatf("unexpected character 0x%02h last %0b",
                               out_i.tx_byte, out_i.last));
        end else begin
          next_char = report_q.pop_front();
          if (out_i.tx_byte !== next_char.tx_byte) begin
            flag_error($sformatf("tx_byte 0x%02h, expected 0x%02h",
                                 out_i.tx_byte, next_char.tx_byte));
          end
          if (out_i.last !== next_char.last) begin
            flag_error($sformatf("last %0b, expected %0b", out_i.last, next_char.last));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_request(in_i);
      end
      pending_o <= report_q.size();
      errors_o  <= mismatches;
    end
  end

endmodule
`default_nettype wire

[dv/serial_set_time_of_day_clock_tb.sv]
`default_nettype none
module serial_set_time_of_day_clock_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic        ActTick     = 1'b0;
  localparam logic        ActByte     = 1'b1;
  localparam logic [7:0]  CharColon   = 8'h3A;
  localparam int unsigned SetLength   = 8;
  // A tick keeps the block busy while it emits its report; long stall runs stay far below this limit.
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 40;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  sstc_pkg::in_t  in_req = '0;
  logic           in_stall;
  logic           out_valid;
  logic           out_stall = 1'b0;
  sstc_pkg::out_t out_char;

  int unsigned chars_pending;
  int unsigned error_count;
  int unsigned src_idle_pct = 21;
  int unsigned dst_stall_pct = 52;
  int unsigned quiet_cycles = 0;
  // Every accepted request, ignored ones included.
  int unsigned sent_requests = 0;

  serial_set_time_of_day_clock uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_char)
  );

  serial_set_time_of_day_clock_check u_report_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_char),
    .pending_o   (chars_pending),
    .errors_o    (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_request(input logic act, input logic [7:0] rx);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= sstc_pkg::in_t'{action: act, rx_byte: rx};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_requests++;
  endtask

  // Sender pause: hold off until every predicted character has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  function automatic logic [0:7][7:0] time_text(input int unsigned hh, mm, ss);
    return {8'(sstc_pkg::AsciiZero + hh / 10), 8'(sstc_pkg::AsciiZero + hh % 10), CharColon,
            8'(sstc_pkg::AsciiZero + mm / 10), 8'(sstc_pkg::AsciiZero + mm % 10), CharColon,
            8'(sstc_pkg::AsciiZero + ss / 10), 8'(sstc_pkg::AsciiZero + ss % 10)};
  endfunction

  task automatic send_set(input logic [0:7][7:0] text);
    send_request(ActByte, sstc_pkg::CharPercent);
    for (int i = 0; i < SetLength; i++) send_request(ActByte, text[i]);
  endtask

  // One random sequence: mostly well-formed settings and ticks, some broken or noise.
  task automatic random_burst();
    int unsigned kind;
    int unsigned hh;
    int unsigned mm;
    int unsigned ss;
    int unsigned cut;
    logic [0:7][7:0] text;
    kind = $urandom_range(99);
    hh   = $urandom_range(23);
    mm   = $urandom_range(59);
    ss   = $urandom_range(59);
    if ($urandom_range(1)) begin
      ss = $urandom_range(56, 59);
      if ($urandom_range(1)) mm = 59;
      if ($urandom_range(1)) hh = 23;
    end
    text = time_text(hh, mm, ss);
    if (kind < 40) begin
      repeat ($urandom_range(1, 4)) send_request(ActTick, 8'($urandom));
    end else if (kind < 70) begin
      send_set(text);
      repeat ($urandom_range(1, 3)) send_request(ActTick, 8'($urandom));
    end else if (kind < 80) begin
      // Arbitrary bytes land in every position, separators included.
      send_set({$urandom, $urandom});
      send_request(ActTick, 8'($urandom));
    end else if (kind < 92) begin
      // A setting cut short by a dropped tick, a restart, or left unfinished.
      cut = $urandom_range(1, SetLength - 1);
      send_request(ActByte, sstc_pkg::CharPercent);
      for (int i = 0; i < cut; i++) send_request(ActByte, text[i]);
      if ($urandom_range(1)) send_request(ActTick, 8'($urandom));
      if ($urandom_range(1)) send_set(text);
    end else begin
      send_request(logic'($urandom_range(1)), 8'($urandom));
    end
  endtask

  task automatic run_random(input int unsigned goal);
    while (sent_requests < goal) random_burst();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tick from reset, then bytes that are ignored outside set mode.
    send_request(ActTick, 8'h00);
    send_request(ActByte, 8'h00);
    send_request(ActByte, 8'hFF);
    // Seconds, minutes and hours all wrap on one tick.
    send_set(time_text(23, 59, 59));
    send_request(ActTick, 8'hFF);
    // A tick in set mode is dropped and a second percent sign restarts the setting.
    send_request(ActByte, sstc_pkg::CharPercent);
    send_request(ActByte, 8'h31);
    send_request(ActByte, 8'h32);
    send_request(ActTick, 8'h5A);
    // Non-digit bytes are stored less the ASCII zero offset and advanced as plain numbers.
    send_set({8'h00, 8'hFF, CharColon, 8'h30, 8'h39, CharColon, 8'h35, 8'h39});
    send_request(ActTick, 8'hA5);
    wait_drained();

    run_random(143);
    wait_drained();

    src_idle_pct = 52;
    dst_stall_pct <= 21;
    run_random(287);
    wait_drained();

    src_idle_pct = 0;
    dst_stall_pct <= 0;
    run_random(430);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
